FILE: src/cgrc_pkg.sv
// Shared types and constants for the character grid rectangle clear block.
// Depends on nothing; every other file but cgrc_ram imports it.
package cgrc_pkg;

    // Field widths fixed by the command and result formats
    localparam int FUNC_W = 3;
    localparam int POS_W  = 12;
    localparam int DATA_W = 16;
    localparam int CFG_W  = 6;

    // Normalised pixel coordinate and divider operand width
    localparam int DIV_W = POS_W + 1;
    // Remainder of the shift-subtract divider (always below twice the divisor)
    localparam int REM_W = CFG_W + 1;
    // Signed cell coordinate width, wide enough for origin plus rounded-up size
    localparam int CRD_W = POS_W + 3;

    // Grid geometry defaults and the widest indexes the command queue carries
    localparam int GRID_COLS_DEF = 32;
    localparam int GRID_ROWS_DEF = 16;
    localparam int COL_MAX_W     = 7;
    localparam int ROW_MAX_W     = 6;

    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CELL_W = 1'b0;
    localparam logic REG_CELL_H = 1'b1;
    localparam logic [CFG_W-1:0] CELL_W_RST = CFG_W'(12);
    localparam logic [CFG_W-1:0] CELL_H_RST = CFG_W'(18);

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE      = 3'd0,
        FN_READ       = 3'd1,
        FN_CLEAR_ALL  = 3'd2,
        FN_CLEAR_CELL = 3'd3,
        FN_CLEAR_PIX  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_OOG   = 3'd3,
        OP_NONE  = 3'd4
    } t_op;

    typedef struct packed {
        logic        [FUNC_W-1:0] func;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  rect_w;
        logic signed [POS_W-1:0]  rect_h;
        logic        [DATA_W-1:0] cell_data;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              out_of_grid;
    } t_out_res;

    typedef struct packed {
        logic [CFG_W-1:0] cell_w;
        logic [CFG_W-1:0] cell_h;
    } t_cfg;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_op                  op;
        logic [COL_MAX_W-1:0] x0;
        logic [COL_MAX_W-1:0] x1;
        logic [ROW_MAX_W-1:0] y0;
        logic [ROW_MAX_W-1:0] y1;
        logic [DATA_W-1:0]    data;
    } t_cmd;

endpackage

FILE: src/cgrc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module cgrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/cgrc_div.sv
// Shift-subtract divider, one quotient bit per cycle, for pixel-to-cell mapping.
// Depends on cgrc_pkg.
module cgrc_div import cgrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CFG_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [CFG_W-1:0] r_dvs;

    logic [REM_W-1:0] shifted;
    logic             ge;

    assign shifted = {r_rem[REM_W-2:0], r_quo[DIV_W-1]};
    assign ge      = shifted >= REM_W'(r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - REM_W'(r_dvs)) : shifted;
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

FILE: src/cgrc_fifo.sv
// Short command queue between the front and back parts.
// Depends on cgrc_pkg.
module cgrc_fifo import cgrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

FILE: src/cgrc_front.sv
// Front part: accepts requests, maps pixel rectangles to cells, clips, and queues commands.
// Depends on cgrc_pkg and cgrc_div.
module cgrc_front import cgrc_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in_req i_in_data,
    input  t_cfg    i_cfg,
    input  logic    i_init_busy,
    output logic    o_push,
    output t_cmd    o_cmd,
    input  logic    i_full
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam logic signed [CRD_W-1:0] COLS_S = CRD_W'(GRID_COLS);
    localparam logic signed [CRD_W-1:0] ROWS_S = CRD_W'(GRID_ROWS);

    t_fstate r_state, n_state;

    logic        [FUNC_W-1:0] r_func;
    logic signed [DIV_W-1:0]  r_nx, r_ny;
    logic        [DIV_W-1:0]  r_nw, r_nh;
    logic signed [CRD_W-1:0]  r_sx, r_ex, r_sy, r_ey;
    logic        [DATA_W-1:0] r_data;
    logic        [1:0]        r_dsel;
    logic                     r_dstart;

    logic [CFG_W-1:0] cw_eff, ch_eff;
    logic             accept;

    logic signed [DIV_W-1:0] x13, y13, w13, h13;
    logic signed [DIV_W-1:0] in_nx, in_ny;
    logic        [DIV_W-1:0] in_nw, in_nh;

    logic [DIV_W-1:0] dvd;
    logic [CFG_W-1:0] dvs;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic signed [CRD_W-1:0] q_s;

    logic signed [CRD_W-1:0] lo_x, hi_x, lo_y, hi_y, last_x, last_y;
    logic                    rect_ok, cell_ok;

    assign cw_eff = (i_cfg.cell_w == '0) ? CFG_W'(1) : i_cfg.cell_w;
    assign ch_eff = (i_cfg.cell_h == '0) ? CFG_W'(1) : i_cfg.cell_h;

    assign o_in_stall = (r_state != F_IDLE) || i_init_busy;
    assign accept     = i_in_valid && !o_in_stall;

    // Normalise a negative size: move the origin back and flip the size
    always_comb begin
        x13   = DIV_W'(i_in_data.pos_x);
        y13   = DIV_W'(i_in_data.pos_y);
        w13   = DIV_W'(i_in_data.rect_w);
        h13   = DIV_W'(i_in_data.rect_h);
        in_nx = (w13 < 0) ? x13 + w13 : x13;
        in_ny = (h13 < 0) ? y13 + h13 : y13;
        in_nw = (w13 < 0) ? $unsigned(-w13) : $unsigned(w13);
        in_nh = (h13 < 0) ? $unsigned(-h13) : $unsigned(h13);
    end

    // Divider operands: origin magnitude, then size rounded up, per axis
    always_comb begin
        case (r_dsel)
            2'd0: begin
                dvd = (r_nx < 0) ? $unsigned(-r_nx) : $unsigned(r_nx);
                dvs = cw_eff;
            end
            2'd1: begin
                dvd = r_nw + DIV_W'(cw_eff) - DIV_W'(1);
                dvs = cw_eff;
            end
            2'd2: begin
                dvd = (r_ny < 0) ? $unsigned(-r_ny) : $unsigned(r_ny);
                dvs = ch_eff;
            end
            default: begin
                dvd = r_nh + DIV_W'(ch_eff) - DIV_W'(1);
                dvs = ch_eff;
            end
        endcase
    end

    cgrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign q_s = $signed(CRD_W'(div_quot));

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_in_data.func == FN_CLEAR_PIX) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (div_done && r_dsel == 2'd3) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_dsel   <= '0;
            r_dstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= 1'b0;
            if (accept && i_in_data.func == FN_CLEAR_PIX) begin
                r_dsel   <= '0;
                r_dstart <= 1'b1;
            end else if (r_state == F_DIV && div_done && r_dsel != 2'd3) begin
                r_dsel   <= r_dsel + 2'd1;
                r_dstart <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_in_data.func;
            r_nx   <= in_nx;
            r_ny   <= in_ny;
            r_nw   <= in_nw;
            r_nh   <= in_nh;
            r_data <= i_in_data.cell_data;
            if (i_in_data.func == FN_WRITE || i_in_data.func == FN_READ) begin
                r_sx <= CRD_W'(i_in_data.pos_x);
                r_sy <= CRD_W'(i_in_data.pos_y);
            end else begin
                r_sx <= CRD_W'(in_nx);
                r_sy <= CRD_W'(in_ny);
                r_ex <= CRD_W'(in_nx) + $signed(CRD_W'(in_nw));
                r_ey <= CRD_W'(in_ny) + $signed(CRD_W'(in_nh));
            end
        end else if (r_state == F_DIV && div_done) begin
            case (r_dsel)
                2'd0:    r_sx <= (r_nx < 0) ? -q_s : q_s;
                2'd1:    r_ex <= r_sx + q_s;
                2'd2:    r_sy <= (r_ny < 0) ? -q_s : q_s;
                default: r_ey <= r_sy + q_s;
            endcase
        end
    end

    // Clip to the grid: start at zero at least, end at the grid edge at most
    always_comb begin
        lo_x    = (r_sx < 0) ? '0 : r_sx;
        lo_y    = (r_sy < 0) ? '0 : r_sy;
        hi_x    = (r_ex > COLS_S) ? COLS_S : r_ex;
        hi_y    = (r_ey > ROWS_S) ? ROWS_S : r_ey;
        last_x  = hi_x - CRD_W'(1);
        last_y  = hi_y - CRD_W'(1);
        rect_ok = (hi_x > lo_x) && (hi_y > lo_y);
        cell_ok = (r_sx >= 0) && (r_sx < COLS_S) && (r_sy >= 0) && (r_sy < ROWS_S);
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.data = r_data;
        case (r_func)
            FN_WRITE, FN_READ: begin
                o_cmd.op = cell_ok ? ((r_func == FN_WRITE) ? OP_WRITE : OP_READ) : OP_OOG;
                o_cmd.x0 = COL_MAX_W'(r_sx);
                o_cmd.y0 = ROW_MAX_W'(r_sy);
            end
            FN_CLEAR_ALL: begin
                o_cmd.op = OP_CLEAR;
                o_cmd.x1 = COL_MAX_W'(GRID_COLS - 1);
                o_cmd.y1 = ROW_MAX_W'(GRID_ROWS - 1);
            end
            FN_CLEAR_CELL, FN_CLEAR_PIX: begin
                o_cmd.op = rect_ok ? OP_CLEAR : OP_NONE;
                o_cmd.x0 = COL_MAX_W'(lo_x);
                o_cmd.x1 = COL_MAX_W'(last_x);
                o_cmd.y0 = ROW_MAX_W'(lo_y);
                o_cmd.y1 = ROW_MAX_W'(last_y);
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
endmodule

FILE: src/cgrc_back.sv
// Back part: executes queued commands against the grid RAM and holds the result register.
// Depends on cgrc_pkg and cgrc_ram.
module cgrc_back import cgrc_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    output logic     o_init_busy,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [4:0] {
        B_INIT   = 5'b00001,
        B_IDLE   = 5'b00010,
        B_READ   = 5'b00100,
        B_SWEEP  = 5'b01000,
        B_RESULT = 5'b10000
    } t_bstate;

    t_bstate r_state;
    t_cmd    r_cmd;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_out_res r_res;
    t_out_res r_out;
    logic     r_out_valid;

    logic sweeping;
    logic [COL_W-1:0] first_col, last_col, cmd_col;
    logic [ROW_W-1:0] last_row, cmd_row;
    logic [AW-1:0]    cmd_addr, sweep_addr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    logic             out_free;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_init_busy = (r_state == B_INIT);
    assign sweeping    = (r_state == B_INIT) || (r_state == B_SWEEP);

    assign cmd_col    = i_cmd.x0[COL_W-1:0];
    assign cmd_row    = i_cmd.y0[ROW_W-1:0];
    assign cmd_addr   = AW'(cmd_row) * AW'(GRID_COLS) + AW'(cmd_col);
    assign sweep_addr = AW'(r_row) * AW'(GRID_COLS) + AW'(r_col);

    // The reset pass walks the whole grid, a clear walks the queued bounds
    assign first_col = (r_state == B_INIT) ? '0 : r_cmd.x0[COL_W-1:0];
    assign last_col  = (r_state == B_INIT) ? COL_W'(GRID_COLS - 1) : r_cmd.x1[COL_W-1:0];
    assign last_row  = (r_state == B_INIT) ? ROW_W'(GRID_ROWS - 1) : r_cmd.y1[ROW_W-1:0];

    assign we    = sweeping || (o_pop && i_cmd.op == OP_WRITE);
    assign waddr = sweeping ? sweep_addr : cmd_addr;
    assign wdata = sweeping ? '0 : i_cmd.data;

    cgrc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (cmd_addr),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_INIT, B_SWEEP: begin
                    if (r_col == last_col) begin
                        r_col <= first_col;
                        if (r_row == last_row) begin
                            r_state <= (r_state == B_INIT) ? B_IDLE : B_RESULT;
                        end else begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.op)
                            OP_READ:  r_state <= B_READ;
                            OP_CLEAR: begin
                                r_col   <= cmd_col;
                                r_row   <= cmd_row;
                                r_state <= B_SWEEP;
                            end
                            default:  r_state <= B_RESULT;
                        endcase
                    end
                end
                B_READ:   r_state <= B_RESULT;
                B_RESULT: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default:  r_state <= B_IDLE;
            endcase

            if (r_state == B_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd             <= i_cmd;
            r_res.read_data   <= '0;
            r_res.out_of_grid <= (i_cmd.op == OP_OOG);
        end else if (r_state == B_READ) begin
            r_res.read_data <= rdata;
        end
        if (r_state == B_RESULT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: src/char_grid_rect_clear.sv
// Top level of the character grid store with cell and rectangle clear commands.
// Depends on cgrc_pkg, cgrc_front, cgrc_fifo and cgrc_back.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------
//  in      | into      | i_in_valid / o_in_stall | i_in_data  (t_in_req)
//  out     | out of    | o_out_valid / i_out_stall | o_out_data (t_out_res)
//  cfg     | into      | psel / penable / pready | paddr, pwdata, prdata
//
// Order: a write passes the front's push state, the queue and the back's result
// state, a read also the back's read state; the front takes a new request only
// once it has pushed the last, and the queue lets it run ahead of the back. A
// rectangle clear sweeps its cells through the single RAM write port, and a pixel
// rectangle first takes four passes of the shared one-bit-per-cycle divider.
// Reset: a clearing pass over all GRID_COLS*GRID_ROWS cells zeroes the grid; the
// in channel stalls throughout, while configuration writes are taken.
// Stalls: the result register holds while o_out stalls; the queue absorbs the
// next request, and the in channel stalls once the queue is full.
module char_grid_rect_clear import cgrc_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [CFG_W-1:0] r_cell_w;
    logic [CFG_W-1:0] r_cell_h;
    t_cfg             cfg;
    logic             cfg_wr;

    logic init_busy;
    logic push, pop, full, empty;
    t_cmd push_cmd, pop_cmd;

    // Register file: one word per register, selected by paddr[2]; the low
    // address bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= CELL_W_RST;
            r_cell_h <= CELL_H_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CELL_W) begin
                r_cell_w <= pwdata[CFG_W-1:0];
            end else begin
                r_cell_h <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CELL_W) ? APB_DATA_W'(r_cell_w) : APB_DATA_W'(r_cell_h);

    assign cfg.cell_w = r_cell_w;
    assign cfg.cell_h = r_cell_h;

    // Front: accept, map pixel rectangles to cells, clip, classify
    cgrc_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    // Queue: decouple classification from execution
    cgrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    // Back: run writes, reads and clear sweeps on the grid RAM
    cgrc_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

FILE: src/cgrc_check.sv
// Port-level checker for the character grid block, bound to the top level.
// Depends on cgrc_pkg.
module cgrc_check import cgrc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_req               i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_res              o_out_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);
    // Reset drops any pending result
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // The grid clearing pass keeps requests out right after reset
    a_reset_stalls_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request accepted during the reset clearing pass");

    // A stalled request holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled request changed");

    // A register write reads back on the same address
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) |=>
            (paddr[2] != $past(paddr[2])) || (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
        else $error("configuration register does not read back");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
endmodule

bind char_grid_rect_clear cgrc_check u_cgrc_check (.*);
